>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/bgwp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgwp_pkg
// Types and constants of the burst and gap waveform player.
// ----------------------------------------------------------------------------
package bgwp_pkg;

	localparam int BURST_LEN = 15;
	localparam int GAP_LEN   = 60;

	localparam int SAMPLE_W = 10;
	localparam int INDEX_W  = 6;
	localparam int ACTION_W = 2;
	localparam int REPEAT_W = 8;
	localparam int HIGH_W   = 8;
	localparam int LOW_W    = 2;

	localparam int BURST_AW = (BURST_LEN > 1) ? $clog2(BURST_LEN) : 1;
	localparam int GAP_AW   = $clog2(GAP_LEN);
	localparam int BURST_PW = $clog2(BURST_LEN + 1);
	localparam int GAP_PW   = $clog2(GAP_LEN + 2);

	localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_BURST_WR = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_GAP_WR   = 2'd2;

	typedef struct packed {
		logic                burst_we;
		logic                gap_we;
		logic [INDEX_W-1:0]  addr;
		logic [SAMPLE_W-1:0] data;
	} bgwp_wr_t;

	typedef struct packed {
		logic                en;
		logic                gap;
		logic [BURST_AW-1:0] burst_addr;
		logic [GAP_AW-1:0]   gap_addr;
	} bgwp_rd_t;

endpackage

>>> rtl/bgwp_tables.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgwp_tables
// Burst and gap sample memories with one write and one registered read.
// ----------------------------------------------------------------------------
module bgwp_tables (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bgwp_pkg::bgwp_wr_t        wr,
	input  bgwp_pkg::bgwp_rd_t        rd,
	output logic [bgwp_pkg::SAMPLE_W-1:0] rd_data
);
	import bgwp_pkg::*;

	logic [SAMPLE_W-1:0] burst_mem [BURST_LEN];
	logic [SAMPLE_W-1:0] gap_mem [GAP_LEN];
	logic [SAMPLE_W-1:0] burst_rd_q;
	logic [SAMPLE_W-1:0] gap_rd_q;
	logic                rd_gap_q;

	always_ff @(posedge clk) begin
		if (wr.burst_we) begin
			burst_mem[wr.addr[BURST_AW-1:0]] <= wr.data;
		end
		if (rd.en && !rd.gap) begin
			burst_rd_q <= burst_mem[rd.burst_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.gap_we) begin
			gap_mem[wr.addr[GAP_AW-1:0]] <= wr.data;
		end
		if (rd.en && rd.gap) begin
			gap_rd_q <= gap_mem[rd.gap_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_gap_q <= 1'b0;
		end else if (rd.en) begin
			rd_gap_q <= rd.gap;
		end
	end

	assign rd_data = rd_gap_q ? gap_rd_q : burst_rd_q;

endmodule

>>> rtl/burst_gap_waveform_player_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burst_gap_waveform_player_top
// Tick-driven sample player for a split 10-bit DAC.
// ----------------------------------------------------------------------------
// The request channel (item_valid, item_stall) carries ticks and table writes.
// A write loads one burst or gap table entry; a write past a table's end and
// action code 3 are dropped. A tick plays the next burst sample, or the next
// even gap entry once burst_repeats passes are done, or is an idle tick.
// The sample channel (sample_valid, sample_stall) returns the played sample
// as dac_high_bits and dac_low_bits, via the table read and output registers.
// One request is taken every cycle while item_stall is low; the throughput
// is set by the single table read per tick, registered in the table memory.
// When the receiver stalls, one result waits in the output register and
// one more in the read stage; only then is item_stall raised.
// burst_repeats is written over its own valid and ready channel, always ready;
// the user writes it only while the player is idle, not enforced by the block.
// Reset clears the positions and the pass count and sets burst_repeats to
// four; the table contents are undefined until written.
// ----------------------------------------------------------------------------
module burst_gap_waveform_player_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [bgwp_pkg::ACTION_W-1:0] action,
	input  logic [bgwp_pkg::INDEX_W-1:0]  table_index,
	input  logic [bgwp_pkg::SAMPLE_W-1:0] table_value,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bgwp_pkg::REPEAT_W-1:0] burst_repeats,
	output logic                          sample_valid,
	input  logic                          sample_stall,
	output logic [bgwp_pkg::HIGH_W-1:0]   dac_high_bits,
	output logic [bgwp_pkg::LOW_W-1:0]    dac_low_bits
);
	import bgwp_pkg::*;

	logic [REPEAT_W-1:0] burst_repeats_q;
	logic [REPEAT_W-1:0] pass_count_q;
	logic [BURST_PW-1:0] burst_pos_q;
	logic [GAP_PW-1:0]   gap_pos_q;
	logic                valid_s1;
	logic                sample_valid_q;
	logic [HIGH_W-1:0]   dac_high_q;
	logic [LOW_W-1:0]    dac_low_q;

	logic                accept;
	logic                advance;
	logic                is_tick;
	logic                in_burst;
	logic                burst_play;
	logic                gap_play;
	logic [SAMPLE_W-1:0] rd_data;
	bgwp_wr_t            wr;
	bgwp_rd_t            rd;

	assign advance    = !sample_valid_q || !sample_stall;
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	assign is_tick    = (action == ACT_TICK);
	assign in_burst   = pass_count_q < burst_repeats_q;
	assign burst_play = in_burst && (burst_pos_q < BURST_PW'(BURST_LEN));
	assign gap_play   = !in_burst && (gap_pos_q < GAP_PW'(GAP_LEN));

	always_comb begin
		wr.burst_we = 1'b0;
		wr.gap_we   = 1'b0;
		wr.addr     = table_index;
		wr.data     = table_value;
		case (action)
			ACT_BURST_WR: begin
				wr.burst_we = accept && ({1'b0, table_index} < (INDEX_W + 1)'(BURST_LEN));
			end
			ACT_GAP_WR: begin
				wr.gap_we = accept && ({1'b0, table_index} < (INDEX_W + 1)'(GAP_LEN));
			end
			default: begin
				wr.burst_we = 1'b0;
			end
		endcase
	end

	assign rd.en         = accept && is_tick && (burst_play || gap_play);
	assign rd.gap        = !in_burst;
	assign rd.burst_addr = burst_pos_q[BURST_AW-1:0];
	assign rd.gap_addr   = gap_pos_q[GAP_AW-1:0];

	bgwp_tables u_tables (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_repeats_q <= REPEAT_W'(4);
		end else if (cfg_valid && cfg_ready) begin
			burst_repeats_q <= burst_repeats;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_count_q <= '0;
			burst_pos_q  <= '0;
			gap_pos_q    <= '0;
		end else if (accept && is_tick) begin
			if (burst_play) begin
				burst_pos_q <= burst_pos_q + BURST_PW'(1);
			end else if (in_burst) begin
				burst_pos_q  <= '0;
				pass_count_q <= pass_count_q + REPEAT_W'(1);
			end else if (gap_play) begin
				gap_pos_q <= gap_pos_q + GAP_PW'(2);
			end else begin
				gap_pos_q    <= '0;
				pass_count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			sample_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= rd.en;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				sample_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			dac_high_q <= rd_data[SAMPLE_W-1:LOW_W];
			dac_low_q  <= rd_data[LOW_W-1:0];
		end
	end

	assign sample_valid  = sample_valid_q;
	assign dac_high_bits = dac_high_q;
	assign dac_low_bits  = dac_low_q;

endmodule

>>> rtl/bgwp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgwp_checker
// Port-level checks of the waveform player, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bgwp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_valid,
	input logic                          item_stall,
	input logic [bgwp_pkg::ACTION_W-1:0] action,
	input logic                          sample_valid,
	input logic                          sample_stall,
	input logic [bgwp_pkg::HIGH_W-1:0]   dac_high_bits,
	input logic [bgwp_pkg::LOW_W-1:0]    dac_low_bits
);
	import bgwp_pkg::*;

	`ASSERT_NEXT(a_sample_hold, sample_valid && sample_stall, sample_valid && $stable(dac_high_bits) && $stable(dac_low_bits), "stalled sample changed")
	`ASSERT_ALWAYS(a_stall_cause, !item_stall || (sample_valid && sample_stall), "request stalled without a stalled sample")
	`ASSERT_ALWAYS(a_sample_source, !$rose(sample_valid) || $past(item_valid && !item_stall && (action == ACT_TICK), 2), "sample without an accepted tick")

endmodule

bind burst_gap_waveform_player_top bgwp_checker u_bgwp_checker (.*);
